// ===== rtl/pste_pkg.sv =====
// Package for the prefix sum tree engine: field widths, command codes and
// the control word passed from the walk sequencer to the partial sum store.
// Depends on nothing.
package pste_pkg;

   localparam int unsigned SUM_W   = 64;
   localparam int unsigned INDEX_W = 11;
   localparam int unsigned AMT_W   = 32;

   localparam logic [INDEX_W-1:0] ACTIVE_SIZE_RESET = 11'd1024;

   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_cmd_type;

endpackage

// ===== rtl/prefix_sum_tree_engine.sv =====
// Binary indexed tree of signed 64-bit partial sums over positions 1..size,
// size being the smaller of the active size register and MAX_POSITIONS. An
// add word (no response) walks up the tree, reading and rewriting one entry
// per tree level it touches; a range query reads the entries on its two
// prefix walks in turn and then offers its result. A new word is taken only
// once the walk of the last one is over. The walks are paced by the single
// read port of the partial sum memory, which serves one tree node per cycle.
// After reset the memory is zeroed by a sweep over all MAX_POSITIONS entries,
// during which req_stall stays high; csr writes are taken at any time.
module prefix_sum_tree_engine #(
   parameter int unsigned MAX_POSITIONS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_cmd,
   input  logic [pste_pkg::INDEX_W-1:0]      req_first_index,
   input  logic [pste_pkg::INDEX_W-1:0]      req_last_index,
   input  logic signed [pste_pkg::AMT_W-1:0] req_amount,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [pste_pkg::SUM_W-1:0] rsp_range_sum,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pste_pkg::INDEX_W-1:0]      csr_active_size
);
   import pste_pkg::*;

   localparam int unsigned AW = $clog2(MAX_POSITIONS);

   logic [INDEX_W-1:0] active_size_ff, active_size_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]   rsp_sum_ff, rsp_sum_in;

   mem_cmd_type        mem_cmd;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [SUM_W-1:0]   wr_data, rd_data;
   logic               store_busy, walk_busy, accept;
   logic               res_valid, res_ready;
   logic [SUM_W-1:0]   res_sum;

   assign csr_ready      = 1'b1;
   assign active_size_in = (csr_valid && csr_ready) ? csr_active_size : active_size_ff;

   assign req_stall = walk_busy || store_busy;
   assign accept    = req_valid && !req_stall;

   // The output register frees the sequencer as soon as a result is parked.
   assign res_ready    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = res_valid ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_sum_in   = (res_valid && res_ready) ? res_sum : rsp_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_size_ff <= ACTIVE_SIZE_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         active_size_ff <= active_size_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sum_ff <= rsp_sum_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = rsp_sum_ff;

   pste_walker #(
      .MAX_POSITIONS (MAX_POSITIONS)
   ) u_walker (
      .clock       (clock),
      .reset       (reset),
      .start       (accept),
      .cmd         (req_cmd),
      .first_index (req_first_index),
      .last_index  (req_last_index),
      .amount      (req_amount),
      .active_size (active_size_ff),
      .busy        (walk_busy),
      .mem_cmd     (mem_cmd),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_sum     (res_sum)
   );

   pste_store #(
      .MAX_POSITIONS (MAX_POSITIONS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mem_cmd),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .busy    (store_busy)
   );

`ifndef ASSERT_OFF
   // A finished result never overwrites one that is still waiting.
   a_no_result_overrun: assert property (
      @(posedge clock) disable iff (reset)
      (res_valid && rsp_valid_ff && rsp_stall) |=> (rsp_sum_ff == $past(rsp_sum_ff))
   ) else $error("waiting result overwritten");
`endif

endmodule

// ===== rtl/pste_store.sv =====
// Partial sum store: one synchronous memory with a registered read port,
// a write port and a zeroing sweep after reset.
// Depends on pste_pkg.
module pste_store #(
   parameter int unsigned MAX_POSITIONS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pste_pkg::mem_cmd_type               cmd,
   input  logic [$clog2(MAX_POSITIONS)-1:0]    wr_addr,
   input  logic [pste_pkg::SUM_W-1:0]          wr_data,
   input  logic [$clog2(MAX_POSITIONS)-1:0]    rd_addr,
   output logic [pste_pkg::SUM_W-1:0]          rd_data,
   output logic                                busy
);
   import pste_pkg::*;

   localparam int unsigned AW = $clog2(MAX_POSITIONS);

   logic [SUM_W-1:0] mem [MAX_POSITIONS];
   logic [SUM_W-1:0] rd_data_ff;
   logic             clr_active_ff, clr_active_in;
   logic [AW-1:0]    clr_addr_ff, clr_addr_in;

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(MAX_POSITIONS - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_active_ff;

`ifndef ASSERT_OFF
   // The sequencer must stay quiet until the zeroing sweep is over.
   a_no_write_while_clearing: assert property (
      @(posedge clock) disable iff (reset) clr_active_ff |-> !cmd.wr_en
   ) else $error("store written during zeroing sweep");
`endif

endmodule

// ===== rtl/pste_walker.sv =====
// Walk sequencer: runs the upward update walk and the two downward prefix
// walks of a range query against the partial sum store, one read per cycle.
// Depends on pste_pkg.
module pste_walker #(
   parameter int unsigned MAX_POSITIONS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              cmd,
   input  logic [pste_pkg::INDEX_W-1:0]      first_index,
   input  logic [pste_pkg::INDEX_W-1:0]      last_index,
   input  logic signed [pste_pkg::AMT_W-1:0] amount,
   input  logic [pste_pkg::INDEX_W-1:0]      active_size,
   output logic                              busy,
   output pste_pkg::mem_cmd_type             mem_cmd,
   output logic [$clog2(MAX_POSITIONS)-1:0]  wr_addr,
   output logic [pste_pkg::SUM_W-1:0]        wr_data,
   output logic [$clog2(MAX_POSITIONS)-1:0]  rd_addr,
   input  logic [pste_pkg::SUM_W-1:0]        rd_data,
   output logic                              res_valid,
   input  logic                              res_ready,
   output logic [pste_pkg::SUM_W-1:0]        res_sum
);
   import pste_pkg::*;

   localparam int unsigned PW = $clog2(MAX_POSITIONS + 1);
   localparam int unsigned IW = ((PW > INDEX_W) ? PW : INDEX_W) + 1;
   localparam int unsigned AW = $clog2(MAX_POSITIONS);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ADD  = 3'd1;
   localparam logic [2:0] ST_QHI  = 3'd2;
   localparam logic [2:0] ST_QLO  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [IW-1:0]    lo_ff, lo_in;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic [SUM_W-1:0] amt_ff, amt_in;

   logic [IW-1:0] size, first_x, last_x, below_x, hi_x, lo_x;
   logic [IW-1:0] lowbit, up_nxt, down_nxt, rd_idx;

   // Positions above the capacity of the store act as if absent.
   assign size = (IW'(active_size) > IW'(MAX_POSITIONS)) ?
                 IW'(MAX_POSITIONS) : IW'(active_size);

   assign first_x  = IW'(first_index);
   assign last_x   = IW'(last_index);
   assign below_x  = (first_x == '0) ? '0 : first_x - IW'(1);
   assign hi_x     = (last_x > size) ? size : last_x;
   assign lo_x     = (below_x > size) ? size : below_x;
   assign lowbit   = idx_ff & (~idx_ff + IW'(1));
   assign up_nxt   = idx_ff + lowbit;
   assign down_nxt = idx_ff & (idx_ff - IW'(1));

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      lo_in         = lo_ff;
      acc_in        = acc_ff;
      amt_in        = amt_ff;
      mem_cmd.rd_en = 1'b0;
      mem_cmd.wr_en = 1'b0;
      rd_idx        = idx_ff;
      res_valid     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (cmd == CMD_ADD) begin
                  amt_in = {{(SUM_W - AMT_W){amount[AMT_W-1]}}, amount};
                  if (first_x != '0 && first_x <= size) begin
                     mem_cmd.rd_en = 1'b1;
                     rd_idx        = first_x;
                     idx_in        = first_x;
                     state_in      = ST_ADD;
                  end
               end else begin
                  acc_in = '0;
                  lo_in  = lo_x;
                  if (first_index > last_index || hi_x == '0) begin
                     state_in = ST_DONE;
                  end else begin
                     mem_cmd.rd_en = 1'b1;
                     rd_idx        = hi_x;
                     idx_in        = hi_x;
                     state_in      = ST_QHI;
                  end
               end
            end
         end
         ST_ADD: begin
            mem_cmd.wr_en = 1'b1;
            if (up_nxt <= size) begin
               mem_cmd.rd_en = 1'b1;
               rd_idx        = up_nxt;
               idx_in        = up_nxt;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_QHI: begin
            acc_in = acc_ff + rd_data;
            if (down_nxt != '0) begin
               mem_cmd.rd_en = 1'b1;
               rd_idx        = down_nxt;
               idx_in        = down_nxt;
            end else if (lo_ff != '0) begin
               mem_cmd.rd_en = 1'b1;
               rd_idx        = lo_ff;
               idx_in        = lo_ff;
               state_in      = ST_QLO;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_QLO: begin
            acc_in = acc_ff - rd_data;
            if (down_nxt != '0) begin
               mem_cmd.rd_en = 1'b1;
               rd_idx        = down_nxt;
               idx_in        = down_nxt;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      lo_ff  <= lo_in;
      acc_ff <= acc_in;
      amt_ff <= amt_in;
   end

   // Positions run from 1, memory entries from 0.
   assign rd_addr = AW'(rd_idx - IW'(1));
   assign wr_addr = AW'(idx_ff - IW'(1));
   assign wr_data = rd_data + amt_ff;
   assign res_sum = acc_ff;
   assign busy    = (state_ff != ST_IDLE);

`ifndef ASSERT_OFF
   // The update walk writes one entry while it fetches the next one up the tree.
   a_rd_wr_distinct: assert property (
      @(posedge clock) disable iff (reset)
      (mem_cmd.wr_en && mem_cmd.rd_en) |-> (wr_addr != rd_addr)
   ) else $error("read and write of the same entry in one cycle");

   // Every fetched word is consumed by a walk state in the following cycle.
   a_read_consumed: assert property (
      @(posedge clock) disable iff (reset)
      mem_cmd.rd_en |=> (state_ff == ST_ADD || state_ff == ST_QHI || state_ff == ST_QLO)
   ) else $error("memory read issued with no walk step to use it");
`endif

endmodule

// ===== dv/prefix_sum_tree_engine_test.sv =====
// Self-checking testbench for the prefix sum tree engine: random add and range-sum words
// checked against an in-bench binary indexed tree under several active sizes.
// Depends on pste_pkg and prefix_sum_tree_engine from the rtl folder.
`timescale 1ns / 100ps

module prefix_sum_tree_engine_test;

   import pste_pkg::*;

   localparam int unsigned TREE_CAPACITY   = 1024;
   localparam int unsigned ITEMS_PER_PHASE = 125;
   localparam int unsigned SETTLE_CYCLES   = 40;
   localparam int unsigned CYCLE_LIMIT     = 1000000;
   localparam int unsigned RANDOM_SIZE     = 4095;
   localparam int unsigned INDEX_TOP       = (1 << INDEX_W) - 1;

   typedef struct {
      logic                     cmd;
      logic [INDEX_W-1:0]       first_index;
      logic [INDEX_W-1:0]       last_index;
      logic signed [AMT_W-1:0]  amount;
   } tree_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_cmd = CMD_ADD;
   logic [INDEX_W-1:0]       req_first_index = '0;
   logic [INDEX_W-1:0]       req_last_index = '0;
   logic signed [AMT_W-1:0]  req_amount = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [SUM_W-1:0]  rsp_range_sum;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [INDEX_W-1:0]       csr_active_size = ACTIVE_SIZE_RESET;

   // Mirror of the block's tree and size register.
   logic [SUM_W-1:0]         tree_sums [1:TREE_CAPACITY];
   logic [INDEX_W-1:0]       tree_size;

   tree_word_type            pending_words [$];
   logic signed [SUM_W-1:0]  expected_sums [$];
   int unsigned              failures = 0;
   int unsigned              cycle_count = 0;

   prefix_sum_tree_engine #(
      .MAX_POSITIONS(TREE_CAPACITY)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_first_index (req_first_index),
      .req_last_index  (req_last_index),
      .req_amount      (req_amount),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_range_sum   (rsp_range_sum),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_active_size (csr_active_size)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic int unsigned active_limit();
      return (tree_size > TREE_CAPACITY) ? TREE_CAPACITY : int'(tree_size);
   endfunction

   function automatic logic [SUM_W-1:0] prefix_total(int unsigned pos);
      int unsigned      cap;
      logic [SUM_W-1:0] acc;
      cap = active_limit();
      acc = '0;
      if (pos > cap) pos = cap;
      while (pos != 0) begin
         acc += tree_sums[pos];
         pos &= pos - 1;
      end
      return acc;
   endfunction

   function automatic void tree_add(int unsigned pos, logic signed [AMT_W-1:0] amt);
      int unsigned      cap;
      logic [SUM_W-1:0] wide;
      cap = active_limit();
      wide = {{(SUM_W-AMT_W){amt[AMT_W-1]}}, amt};
      if (pos == 0) return;
      while (pos <= cap) begin
         tree_sums[pos] += wide;
         pos += pos & (~pos + 1);
      end
   endfunction

   // Applies one accepted word to the mirror; a query leaves its sum to be checked.
   function automatic void apply_word(tree_word_type w);
      int unsigned below;
      if (w.cmd == CMD_ADD) begin
         tree_add(w.first_index, w.amount);
      end else if (w.first_index > w.last_index) begin
         expected_sums.push_back('0);
      end else begin
         below = (w.first_index == 0) ? 0 : w.first_index - 1;
         expected_sums.push_back(prefix_total(w.last_index) - prefix_total(below));
      end
   endfunction

   // Mostly no pause, some short ones, a few long ones, and now and then a calm stretch with none.
   task automatic pick_pause(inout int unsigned calm, output int unsigned pause);
      int unsigned r;
      pause = 0;
      if (calm != 0) begin
         calm--;
      end else if ($urandom_range(0, 99) < 3) begin
         calm = $urandom_range(30, 150);
      end else begin
         r = $urandom_range(0, 99);
         if (r >= 93) pause = $urandom_range(8, 40);
         else if (r >= 65) pause = $urandom_range(1, 3);
      end
   endtask

   function automatic tree_word_type make_word(logic cmd, int unsigned lo, int unsigned hi,
                                               logic signed [AMT_W-1:0] amt);
      tree_word_type w;
      w.cmd = cmd;
      w.first_index = INDEX_W'(lo);
      w.last_index = INDEX_W'(hi);
      w.amount = amt;
      return w;
   endfunction

   function automatic int unsigned pick_index(int unsigned cap);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (cap != 0 && r < 80) return $urandom_range(1, cap);
      if (r < 88) return 0;
      if (r < 94) return $urandom_range(cap, cap + 1);
      return $urandom_range(0, INDEX_TOP);
   endfunction

   function automatic logic signed [AMT_W-1:0] pick_amount();
      case ($urandom_range(0, 39))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return -32'sd1;
         3: return 32'sd0;
         default: return $urandom();
      endcase
   endfunction

   function automatic tree_word_type random_word(int unsigned cap);
      tree_word_type w;
      int unsigned   lo;
      int unsigned   hi;
      int unsigned   swap;
      lo = pick_index(cap);
      hi = pick_index(cap);
      if ($urandom_range(0, 1) == 0) begin
         w = make_word(CMD_ADD, lo, $urandom_range(0, INDEX_TOP), pick_amount());
      end else begin
         // Most ranges are well ordered; the rest come out empty.
         if (lo > hi && $urandom_range(0, 99) < 75) begin
            swap = lo;
            lo = hi;
            hi = swap;
         end
         w = make_word(CMD_QUERY, lo, hi, $urandom());
      end
      return w;
   endfunction

   // Driver: presents one word at a time and updates the mirror when it is taken.
   tree_word_type held_word;
   int unsigned   send_gap = 0;
   int unsigned   send_calm = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) apply_word(held_word);
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               held_word = pending_words.pop_front();
               req_cmd <= held_word.cmd;
               req_first_index <= held_word.first_index;
               req_last_index <= held_word.last_index;
               req_amount <= held_word.amount;
               req_valid <= 1'b1;
               pick_pause(send_calm, send_gap);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stalls the result side at random and checks each sum in order.
   int unsigned             stall_left = 0;
   int unsigned             stall_calm = 0;
   logic signed [SUM_W-1:0] want_sum;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_sums.size() == 0) begin
               $error("range_sum word with no query waiting: actual %0d", rsp_range_sum);
               failures++;
            end else begin
               want_sum = expected_sums.pop_front();
               if (rsp_range_sum !== want_sum) begin
                  $error("range_sum mismatch: expected %0d, actual %0d", want_sum, rsp_range_sum);
                  failures++;
               end
            end
         end
         if (stall_left == 0) pick_pause(stall_calm, stall_left);
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // An add gives no response, so the engine may still be walking after the last sum.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_sums.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_active_size(int unsigned value);
      @(posedge clock);
      csr_active_size <= INDEX_W'(value);
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      tree_size = INDEX_W'(value);
   endtask

   initial begin
      int unsigned size_plan [11];
      int unsigned next_size;
      size_plan = '{1023, 5, 0, 1, 2, INDEX_TOP, 16, RANDOM_SIZE, 1024, RANDOM_SIZE, 700};
      for (int i = 1; i <= TREE_CAPACITY; i++) tree_sums[i] = '0;
      tree_size = ACTIVE_SIZE_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset size: extremes, ignored adds and odd ranges.
      pending_words.push_back(make_word(CMD_QUERY, 1, 1024, 0));
      pending_words.push_back(make_word(CMD_ADD, 1, 0, 32'sh7fffffff));
      pending_words.push_back(make_word(CMD_ADD, 1024, INDEX_TOP, 32'sh80000000));
      pending_words.push_back(make_word(CMD_ADD, 0, 0, 12345));
      pending_words.push_back(make_word(CMD_ADD, 1025, 0, -1));
      pending_words.push_back(make_word(CMD_ADD, INDEX_TOP, INDEX_TOP, -1));
      pending_words.push_back(make_word(CMD_ADD, 512, 7, -1));
      pending_words.push_back(make_word(CMD_ADD, 3, 9, 0));
      pending_words.push_back(make_word(CMD_ADD, 5, 0, 32'sh12345678));
      pending_words.push_back(make_word(CMD_QUERY, 0, 1024, 0));
      pending_words.push_back(make_word(CMD_QUERY, 1, 1, -1));
      pending_words.push_back(make_word(CMD_QUERY, 5, 4, 0));
      pending_words.push_back(make_word(CMD_QUERY, INDEX_TOP, 0, 32'sh7fffffff));
      pending_words.push_back(make_word(CMD_QUERY, 0, INDEX_TOP, 32'sh80000000));
      pending_words.push_back(make_word(CMD_QUERY, 1024, 1024, 0));
      pending_words.push_back(make_word(CMD_QUERY, 0, 0, 0));
      pending_words.push_back(make_word(CMD_QUERY, 512, 512, 0));
      pending_words.push_back(make_word(CMD_QUERY, 2, 1023, 0));
      pending_words.push_back(make_word(CMD_QUERY, 5, 5, 0));
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
         pending_words.push_back(random_word(active_limit()));
      wait_drained();

      // Each later phase resizes the tree first; a shrink hides adds made beyond it.
      foreach (size_plan[p]) begin
         next_size = (size_plan[p] == RANDOM_SIZE) ? $urandom_range(3, 1023) : size_plan[p];
         write_active_size(next_size);
         pending_words.push_back(make_word(CMD_QUERY, 0, INDEX_TOP, 0));
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            pending_words.push_back(random_word(active_limit()));
         wait_drained();
      end

      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
